/* hdl/wildcard_pattern_matcher_core_assert.svh */
// Assertion macros shared by the wildcard pattern matcher modules.
`ifndef WILDCARD_PATTERN_MATCHER_CORE_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define WPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wpm_pkg.sv */
// Shared types and symbol codes for the wildcard pattern matcher.
package wpm_pkg;

    localparam int SYM_W = 5;

    // Pattern symbols with a wildcard meaning.
    localparam logic [SYM_W-1:0] SYM_ANY_ONE = 5'd26;
    localparam logic [SYM_W-1:0] SYM_ANY_RUN = 5'd27;

    // One input transaction.
    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] symbol;
        logic             restart;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic matched;
        logic truncated;
    } out_item_t;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic             is_text;
        logic             restart;
        logic             is_star;
        logic [SYM_W-1:0] symbol;
    } op_t;

    // Queue status seen by the neighbor stages.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* hdl/wildcard_pattern_matcher_core.sv */
// Top level of the wildcard pattern matcher: front, operation queue, back, result queue.
//
//   Channel   Handshake          Payload
//   -------   ----------------   -------------------------------------
//   input     push / full        item   : mode, symbol, restart
//   result    empty / pop        result : matched, truncated
//
// One transaction per cycle unless a full queue stalls the flow: the back stage closes
// the active set over stars with a single add across the cell row. A result passes through
// the front holding register, the op queue and the result queue before it shows.
// Reset clears the pattern length, the truncation flag and both queues, and
// leaves only position zero active. With pop held low, full rises once five
// transactions wait: two results, two queued operations and one held input.
module wildcard_pattern_matcher_core #(
    parameter int PATTERN_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpm_pkg::in_item_t   item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output wpm_pkg::out_item_t  result
);

    localparam int OP_W  = $bits(wpm_pkg::op_t);
    localparam int RES_W = $bits(wpm_pkg::out_item_t);

    wpm_pkg::fifo_status_t q_status;
    wpm_pkg::fifo_status_t r_status;
    logic                  q_push;
    logic                  q_pop;
    wpm_pkg::op_t          front_op;
    logic [OP_W-1:0]       q_dout;
    wpm_pkg::op_t          back_op;
    logic                  r_push;
    wpm_pkg::out_item_t    back_item;
    logic [RES_W-1:0]      r_dout;

    // Accept and classify.
    wpm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .q_status (q_status),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    // Operation queue between front and back.
    wpm_fifo #(
        .WIDTH (OP_W)
    ) u_op_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .din    (front_op),
        .pop    (q_pop),
        .dout   (q_dout),
        .status (q_status)
    );

    assign back_op = wpm_pkg::op_t'(q_dout);

    // Automaton.
    wpm_back #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_op     (back_op),
        .q_pop    (q_pop),
        .r_status (r_status),
        .r_push   (r_push),
        .r_item   (back_item)
    );

    // Result queue facing the consumer.
    wpm_fifo #(
        .WIDTH (RES_W)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (r_push),
        .din    (back_item),
        .pop    (pop),
        .dout   (r_dout),
        .status (r_status)
    );

    assign result = wpm_pkg::out_item_t'(r_dout);
    assign empty  = r_status.empty;

endmodule

/* hdl/wpm_fifo.sv */
// Two-entry queue used between the front, the back and the result port.
`include "wildcard_pattern_matcher_core_assert.svh"

module wpm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      din,
    input  logic                  pop,
    output logic [WIDTH-1:0]      dout,
    output wpm_pkg::fifo_status_t status
);

    localparam logic [1:0] FIFO_DEPTH = 2'd2;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_write;
    logic             do_read;

    assign status.full  = (count_reg == FIFO_DEPTH);
    assign status.empty = (count_reg == 2'd0);
    assign do_write     = push && !status.full;
    assign do_read      = pop && !status.empty;
    assign dout         = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `WPM_ASSERT_ALWAYS(a_count_bound, count_reg <= FIFO_DEPTH, "queue count beyond depth")
    `WPM_ASSERT_ALWAYS(a_ptr_track, (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg),
        "queue pointers disagree with count")
    `WPM_ASSERT_NEXT(a_write_lands, do_write && !do_read, !status.empty,
        "queue empty after a write")

endmodule

/* hdl/wpm_front.sv */
// Front stage: accepts input transactions and classifies them into operations.
module wpm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wpm_pkg::in_item_t     item,
    output logic                  full,
    input  wpm_pkg::fifo_status_t q_status,
    output logic                  q_push,
    output wpm_pkg::op_t          q_op
);

    logic         op_valid_reg;
    logic         op_valid_next;
    wpm_pkg::op_t op_reg;
    wpm_pkg::op_t op_next;
    logic         load;

    // The holding register frees up whenever the queue can take its content.
    assign full   = op_valid_reg && q_status.full;
    assign load   = push && !full;
    assign q_push = op_valid_reg && !q_status.full;
    assign q_op   = op_reg;

    // Classify the incoming symbol.
    always_comb
    begin
        op_next.is_text = item.mode;
        op_next.restart = item.restart;
        op_next.symbol  = item.symbol;
        op_next.is_star = !item.mode && (item.symbol == wpm_pkg::SYM_ANY_RUN);
        op_valid_next   = load || (op_valid_reg && !q_push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg <= op_next;
        end
    end

endmodule

/* hdl/wpm_back.sv */
// Back stage: pattern cell row and active-position automaton with star closure.
`include "wildcard_pattern_matcher_core_assert.svh"

module wpm_back #(
    parameter int PATTERN_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wpm_pkg::fifo_status_t q_status,
    input  wpm_pkg::op_t          q_op,
    output logic                  q_pop,
    input  wpm_pkg::fifo_status_t r_status,
    output logic                  r_push,
    output wpm_pkg::out_item_t    r_item
);

    localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);
    localparam int IDX_W = $clog2(PATTERN_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PATTERN_DEPTH);

    logic [wpm_pkg::SYM_W-1:0] sym_reg [PATTERN_DEPTH];
    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          len_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic [PATTERN_DEPTH:0]    act_reg;
    logic [PATTERN_DEPTH:0]    init_reg;

    logic                      go;
    logic [LEN_W-1:0]          base_len;
    logic                      room;
    logic [IDX_W-1:0]          wr_idx;
    logic [PATTERN_DEPTH:0]    star_cur;
    logic [PATTERN_DEPTH:0]    star_new;
    logic [PATTERN_DEPTH:0]    stepped;
    logic [PATTERN_DEPTH:0]    base_set;
    logic [PATTERN_DEPTH:0]    set_pre;
    logic [PATTERN_DEPTH:0]    add_a;
    logic [PATTERN_DEPTH:0]    add_b;
    logic [PATTERN_DEPTH:0]    add_sum;
    logic [PATTERN_DEPTH:0]    closed;
    logic [LEN_W-1:0]          len_sel;

    // One operation per cycle whenever there is room for its result.
    assign go     = !q_status.empty && !r_status.full;
    assign q_pop  = go;
    assign r_push = go;

    // Pattern append bookkeeping.
    always_comb
    begin
        base_len = q_op.restart ? '0 : len_reg;
        room     = (base_len < DEPTH_LEN);
        wr_idx   = base_len[IDX_W-1:0];
        len_next = room ? base_len + LEN_W'(1) : base_len;
        ovf_next = (q_op.restart ? 1'b0 : ovf_reg) || !room;
    end

    // Each cell judges its own position against the current text symbol.
    always_comb
    begin
        star_cur = '0;
        star_new = '0;
        stepped  = '0;
        base_set = q_op.restart ? init_reg : act_reg;
        for (int i = 0; i < PATTERN_DEPTH; i++)
        begin
            logic cell_valid;
            logic cell_star;
            logic cell_hit;
            cell_valid  = (LEN_W'(i) < len_reg);
            cell_star   = (sym_reg[i] == wpm_pkg::SYM_ANY_RUN);
            cell_hit    = (sym_reg[i] == wpm_pkg::SYM_ANY_ONE) || (sym_reg[i] == q_op.symbol);
            star_cur[i] = cell_valid && cell_star;
            if (room && (LEN_W'(i) == base_len))
            begin
                star_new[i] = q_op.is_star;
            end
            else
            begin
                star_new[i] = (LEN_W'(i) < len_next) && cell_star;
            end
            if (base_set[i] && cell_valid)
            begin
                if (cell_star)
                begin
                    stepped[i] = 1'b1;
                end
                else if (cell_hit)
                begin
                    stepped[i+1] = 1'b1;
                end
            end
        end
    end

    // Star closure as a carry chain: stars propagate, active stars generate.
    always_comb
    begin
        set_pre = q_op.is_text ? stepped : {{PATTERN_DEPTH{1'b0}}, 1'b1};
        add_a   = q_op.is_text ? star_cur : star_new;
        add_b   = set_pre & add_a;
        add_sum = add_a + add_b;
        closed  = set_pre | (add_sum ^ add_a ^ add_b);
        len_sel = q_op.is_text ? len_reg : len_next;
    end

    assign r_item.matched   = closed[len_sel];
    assign r_item.truncated = q_op.is_text ? ovf_reg : ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            act_reg  <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
            init_reg <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
        end
        else if (go)
        begin
            act_reg <= closed;
            if (!q_op.is_text)
            begin
                len_reg  <= len_next;
                ovf_reg  <= ovf_next;
                init_reg <= closed;
            end
        end
    end

    // Pattern cells hold no reset; only entries below the length are used.
    always_ff @(posedge clk)
    begin
        if (go && !q_op.is_text && room)
        begin
            sym_reg[wr_idx] <= q_op.symbol;
        end
    end

    `WPM_ASSERT_ALWAYS(a_len_bound, len_reg <= DEPTH_LEN, "pattern length beyond store depth")
    `WPM_ASSERT_ALWAYS(a_ovf_full, !ovf_reg || (len_reg == DEPTH_LEN),
        "truncation flagged with a store that is not full")
    `WPM_ASSERT_ALWAYS(a_init_origin, init_reg[0], "restart set lost position zero")
    `WPM_ASSERT_NEXT(a_text_keeps_len, go && q_op.is_text, $stable(len_reg),
        "text transaction changed the pattern length")

endmodule
